>>> hw/rtl/slb_pkg.sv
// Shared types and constants for the server load balancer.
`timescale 1ns / 1ps
package slb_pkg;

   typedef enum logic [2:0] {
      OP_REGISTER   = 3'd0,
      OP_UNREGISTER = 3'd1,
      OP_CHOOSE     = 3'd2,
      OP_ADD        = 3'd3,
      OP_TAKE       = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ALREADY   = 3'd1,
      ST_NOT_REG   = 3'd2,
      ST_NO_SERVER = 3'd3,
      ST_DUP       = 3'd4,
      ST_FULL      = 3'd5,
      ST_NOT_FOUND = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      STRAT_RR    = 2'd0,
      STRAT_LEAST = 2'd1,
      STRAT_RESP  = 2'd2
   } strat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SLOT_SCAN,
      S_PEND_SCAN,
      S_FINISH,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request beat
      logic slot_clear; // reset slot scan index
      logic slot_step;  // examine one slot
      logic pend_clear; // reset pending scan index
      logic pend_step;  // examine one pending entry
      logic finish;     // apply result and update state
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_last;
      logic pend_last;
      logic need_slot;  // op needs the slot scan
      logic need_pend;  // op needs the pending scan
   } sts_type;

endpackage

>>> hw/rtl/slb_ctrl.sv
// Sequencing state machine for the server load balancer.
`timescale 1ns / 1ps
module slb_ctrl
   import slb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    csr_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SLOT_SCAN;
         end
         S_SLOT_SCAN: begin
            if (!sts.need_slot || sts.slot_last) state_in = S_PEND_SCAN;
         end
         S_PEND_SCAN: begin
            if (!sts.need_pend || sts.pend_last) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      csr_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall      = 1'b0;
            csr_ready      = 1'b1;
            cmd.load       = req_valid;
            cmd.slot_clear = 1'b1;
            cmd.pend_clear = 1'b1;
         end
         S_SLOT_SCAN: cmd.slot_step = sts.need_slot;
         S_PEND_SCAN: cmd.pend_step = sts.need_pend;
         S_FINISH:    cmd.finish    = 1'b1;
         S_RESP:      rsp_valid     = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> hw/rtl/slb_datapath.sv
// Slot table, pending table and scan logic for the server load balancer.
`timescale 1ns / 1ps
module slb_datapath
   import slb_pkg::*;
#(
   parameter int NUM_SLOTS     = 16,
   parameter int PENDING_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  strategy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_sequence_req,
   input  logic [31:0] req_request_id,
   input  logic [31:0] req_now_ms,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_chosen_slot,
   output logic [31:0] rsp_found_request_id
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int PW = $clog2(PENDING_DEPTH);

   // captured request
   logic [2:0]  op_ff;
   logic [3:0]  slot_ff;
   logic [31:0] seq_ff, tag_ff, now_ff;
   logic        slot_oor;
   logic [SW-1:0] sidx;

   // slot state
   logic [NUM_SLOTS-1:0] slot_valid_ff;
   logic [31:0]          slot_metric_ff [NUM_SLOTS];
   logic [SW:0]          rr_ff;

   // pending table
   logic [PENDING_DEPTH-1:0] pend_valid_ff;
   logic [3:0]  pend_slot_mem [PENDING_DEPTH];
   logic [31:0] pend_seq_mem  [PENDING_DEPTH];
   logic [31:0] pend_tag_mem  [PENDING_DEPTH];
   logic [31:0] pend_time_mem [PENDING_DEPTH];
   logic [3:0]  rd_slot_ff;
   logic [31:0] rd_seq_ff, rd_tag_ff, rd_time_ff;
   logic        rd_live_ff;
   logic [PW-1:0] rd_idx_ff;

   // scan registers
   logic [SW-1:0] sc_ff;
   logic [PW:0]   pc_ff;
   logic          best_ok_ff, zero_ok_ff, first_ok_ff, after_ok_ff;
   logic [SW-1:0] best_ff, first_ff, after_ff;
   logic [31:0]   best_m_ff;
   logic          hit_ok_ff, free_ok_ff;
   logic [PW-1:0] hit_ff, free_ff;
   logic [31:0]   hit_tag_ff, hit_time_ff;

   logic [2:0]  status_ff;
   logic [3:0]  chosen_ff;
   logic [31:0] found_ff;

   assign slot_oor = ({28'd0, slot_ff} >= 32'(NUM_SLOTS));
   assign sidx     = SW'(slot_ff);

   assign sts.need_slot = (op_ff == OP_CHOOSE);
   assign sts.need_pend = !slot_oor &&
                          (op_ff == OP_ADD || op_ff == OP_TAKE ||
                           (op_ff == OP_UNREGISTER && slot_valid_ff[sidx]));
   assign sts.slot_last = (sc_ff == SW'(NUM_SLOTS - 1));
   // one extra step drains the registered read of the last entry
   assign sts.pend_last = (pc_ff == (PW+1)'(PENDING_DEPTH));

   // capture request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         slot_ff <= req_slot;
         seq_ff  <= req_sequence_req;
         tag_ff  <= req_request_id;
         now_ff  <= req_now_ms;
      end
   end

   // slot scan: first zero, first minimum, round robin candidates
   logic [31:0] cur_m;
   assign cur_m = slot_metric_ff[sc_ff];
   always_ff @(posedge clock) begin
      if (cmd.slot_clear) begin
         sc_ff       <= '0;
         best_ok_ff  <= 1'b0;
         zero_ok_ff  <= 1'b0;
         first_ok_ff <= 1'b0;
         after_ok_ff <= 1'b0;
      end else if (cmd.slot_step) begin
         if (!sts.slot_last) sc_ff <= sc_ff + 1'b1;
         if (slot_valid_ff[sc_ff]) begin
            if (!first_ok_ff) begin
               first_ok_ff <= 1'b1;
               first_ff    <= sc_ff;
            end
            if (!after_ok_ff && rr_ff < (SW+1)'(NUM_SLOTS) &&
                {1'b0, sc_ff} > rr_ff) begin
               after_ok_ff <= 1'b1;
               after_ff    <= sc_ff;
            end
            if (!zero_ok_ff) begin
               if (cur_m == 32'd0) begin
                  zero_ok_ff <= 1'b1;
                  best_ok_ff <= 1'b1;
                  best_ff    <= sc_ff;
                  best_m_ff  <= cur_m;
               end else if (!best_ok_ff || cur_m < best_m_ff) begin
                  best_ok_ff <= 1'b1;
                  best_ff    <= sc_ff;
                  best_m_ff  <= cur_m;
               end
            end
         end
      end
   end

   // pending scan: read one entry per cycle, compare the registered read
   logic pend_match;
   assign pend_match = rd_live_ff && rd_slot_ff == slot_ff && rd_seq_ff == seq_ff;
   always_ff @(posedge clock) begin
      if (cmd.pend_clear) begin
         pc_ff      <= '0;
         rd_live_ff <= 1'b0;
         hit_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (cmd.pend_step) begin
         pc_ff <= pc_ff + 1'b1;
         rd_live_ff <= 1'b0;
         if (pc_ff < (PW+1)'(PENDING_DEPTH)) begin
            rd_idx_ff  <= pc_ff[PW-1:0];
            rd_live_ff <= pend_valid_ff[pc_ff[PW-1:0]];
            rd_slot_ff <= pend_slot_mem[pc_ff[PW-1:0]];
            rd_seq_ff  <= pend_seq_mem[pc_ff[PW-1:0]];
            rd_tag_ff  <= pend_tag_mem[pc_ff[PW-1:0]];
            rd_time_ff <= pend_time_mem[pc_ff[PW-1:0]];
            if (!free_ok_ff && !pend_valid_ff[pc_ff[PW-1:0]]) begin
               free_ok_ff <= 1'b1;
               free_ff    <= pc_ff[PW-1:0];
            end
         end
         if (pend_match && !hit_ok_ff) begin
            hit_ok_ff   <= 1'b1;
            hit_ff      <= rd_idx_ff;
            hit_tag_ff  <= rd_tag_ff;
            hit_time_ff <= rd_time_ff;
         end
      end
   end

   // pending memory write (add)
   always_ff @(posedge clock) begin
      if (cmd.finish && op_ff == OP_ADD && !slot_oor && !hit_ok_ff && free_ok_ff) begin
         pend_slot_mem[free_ff] <= slot_ff;
         pend_seq_mem[free_ff]  <= seq_ff;
         pend_tag_mem[free_ff]  <= tag_ff;
         pend_time_mem[free_ff] <= now_ff;
      end
   end

   // pending valid bits; unregister drops entries as the scan passes them
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= '0;
      end else begin
         if (cmd.pend_step && op_ff == OP_UNREGISTER && rd_live_ff &&
             rd_slot_ff == slot_ff)
            pend_valid_ff[rd_idx_ff] <= 1'b0;
         if (cmd.finish && !slot_oor) begin
            if (op_ff == OP_ADD && !hit_ok_ff && free_ok_ff)
               pend_valid_ff[free_ff] <= 1'b1;
            if (op_ff == OP_TAKE && hit_ok_ff)
               pend_valid_ff[hit_ff] <= 1'b0;
         end
      end
   end

   // finish: slot state and result
   logic [SW-1:0] rr_pick;
   logic          rr_ok;
   logic [32:0]   avg_sum;
   logic [31:0]   elapsed;
   assign rr_ok   = after_ok_ff || first_ok_ff;
   assign rr_pick = after_ok_ff ? after_ff : first_ff;
   assign elapsed = now_ff - hit_time_ff;
   assign avg_sum = {1'b0, slot_metric_ff[sidx]} + {1'b0, elapsed};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) slot_metric_ff[i] <= '0;
         rr_ff <= (SW+1)'(NUM_SLOTS);
      end else if (cmd.finish) begin
         if (op_ff == OP_REGISTER && !slot_oor && !slot_valid_ff[sidx]) begin
            slot_valid_ff[sidx]  <= 1'b1;
            slot_metric_ff[sidx] <= '0;
         end
         if (op_ff == OP_UNREGISTER && !slot_oor && slot_valid_ff[sidx]) begin
            slot_valid_ff[sidx]  <= 1'b0;
            slot_metric_ff[sidx] <= '0;
            rr_ff <= (SW+1)'(NUM_SLOTS);
         end
         if (op_ff == OP_CHOOSE && strategy == STRAT_RR && rr_ok) begin
            rr_ff <= {1'b0, rr_pick};
            if (slot_metric_ff[rr_pick] != '1)
               slot_metric_ff[rr_pick] <= slot_metric_ff[rr_pick] + 1'b1;
         end
         if (op_ff == OP_ADD && !slot_oor && !hit_ok_ff && free_ok_ff &&
             strategy == STRAT_LEAST && slot_valid_ff[sidx] &&
             slot_metric_ff[sidx] != '1)
            slot_metric_ff[sidx] <= slot_metric_ff[sidx] + 1'b1;
         if (op_ff == OP_TAKE && !slot_oor && hit_ok_ff && slot_valid_ff[sidx]) begin
            if (strategy == STRAT_LEAST && slot_metric_ff[sidx] != '0)
               slot_metric_ff[sidx] <= slot_metric_ff[sidx] - 1'b1;
            else if (strategy == STRAT_RESP)
               slot_metric_ff[sidx] <= avg_sum[32:1];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= ST_OK;
         chosen_ff <= '0;
         found_ff  <= '0;
         if (op_ff != OP_CHOOSE && op_ff <= OP_TAKE && slot_oor) begin
            status_ff <= ST_NOT_REG;
         end else begin
            case (op_ff)
               OP_REGISTER:
                  if (slot_valid_ff[sidx]) status_ff <= ST_ALREADY;
               OP_UNREGISTER:
                  if (!slot_valid_ff[sidx]) status_ff <= ST_NOT_REG;
               OP_CHOOSE: begin
                  if (strategy == STRAT_RR && rr_ok)
                     chosen_ff <= 4'(rr_pick);
                  else if ((strategy == STRAT_LEAST || strategy == STRAT_RESP) &&
                           best_ok_ff)
                     chosen_ff <= 4'(best_ff);
                  else
                     status_ff <= ST_NO_SERVER;
               end
               OP_ADD: begin
                  if (hit_ok_ff)        status_ff <= ST_DUP;
                  else if (!free_ok_ff) status_ff <= ST_FULL;
               end
               OP_TAKE: begin
                  if (hit_ok_ff) found_ff  <= hit_tag_ff;
                  else           status_ff <= ST_NOT_FOUND;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_chosen_slot      = chosen_ff;
   assign rsp_found_request_id = found_ff;

endmodule

>>> hw/rtl/server_load_balancer_top.sv
// Top level of the server load balancer.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one operation per beat (register, unregister, choose,
//   add record, take record); rsp_* returns exactly one result beat per
//   request. Both channels use valid/stall; the receiver drives stall.
//   csr_* writes the strategy register (valid/ready), only while idle.
// Sequencing:
//   One request at a time. Each request runs the slot scan (choose only),
//   the pending scan (add and take of an in-range slot, unregister of a
//   registered slot; the table is scanned one entry per cycle through its
//   read port, plus one step to drain the registered read), a finish step
//   and the result beat. The block returns to idle after the result is
//   taken, before the next request is accepted.
// Reset:
//   Synchronous, active high. Clears all slots, metrics, the round-robin
//   pointer, pending valid bits and the strategy (round robin).
// Stall:
//   A stalled result beat holds its payload; no new request is taken
//   until the result beat is accepted.
module server_load_balancer_top
   import slb_pkg::*;
#(
   parameter int NUM_SLOTS     = 16,
   parameter int PENDING_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_sequence_req,
   input  logic [31:0] req_request_id,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_chosen_slot,
   output logic [31:0] rsp_found_request_id,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_strategy
);

   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] strategy_ff;

   // hold the strategy register
   always_ff @(posedge clock) begin
      if (reset)                      strategy_ff <= STRAT_RR;
      else if (csr_valid && csr_ready) strategy_ff <= csr_strategy;
   end

   slb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   slb_datapath #(
      .NUM_SLOTS     (NUM_SLOTS),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .strategy             (strategy_ff),
      .req_op               (req_op),
      .req_slot             (req_slot),
      .req_sequence_req     (req_sequence_req),
      .req_request_id       (req_request_id),
      .req_now_ms           (req_now_ms),
      .rsp_status           (rsp_status),
      .rsp_chosen_slot      (rsp_chosen_slot),
      .rsp_found_request_id (rsp_found_request_id)
   );

endmodule
